// ===== rtl/assert_macros.svh =====
// Assertion macros used by the RTL (included by dks_walk)
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only outside reset
`define DKS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked on every clock edge, reset included
`define DKS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== rtl/dks_pkg.sv =====
// ----------------------------------------------------------------------------
// dks_pkg
// Types, tag codes and element tables for the DER key header walker.
// ----------------------------------------------------------------------------
`default_nettype none

package dks_pkg;

  localparam logic [7:0] TAG_INTEGER      = 8'h02;
  localparam logic [7:0] TAG_BIT_STRING   = 8'h03;
  localparam logic [7:0] TAG_OCTET_STRING = 8'h04;
  localparam logic [7:0] TAG_SEQUENCE     = 8'h30;

  localparam logic [7:0] LEN_LONG_BIT = 8'h80;
  localparam logic [7:0] LEN_N_MASK   = 8'h7F;

  localparam logic [1:0] ST_FOUND    = 2'd0;
  localparam logic [1:0] ST_TAG_ERR  = 2'd1;
  localparam logic [1:0] ST_LEN_ERR  = 2'd2;
  localparam logic [1:0] ST_OFF_OVFL = 2'd3;

  localparam logic [2:0] LAST_STEP = 3'd4;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_TAG,
    PH_LEN,
    PH_LEN_HDR,
    PH_LEN_SKIP,
    PH_SKIP
  } phase_t;

  typedef enum logic [1:0] {
    K_HDR,
    K_SKIP,
    K_BITS,
    K_LAST
  } kind_t;

  typedef struct packed {
    logic        hit;
    logic [15:0] key_offset;
    logic [1:0]  status;
  } walk_res_t;

  function automatic logic [7:0] elem_tag(input logic fmt, input logic [2:0] step);
    logic [7:0] t;
    t = TAG_SEQUENCE;
    if (!fmt) begin
      if (step == 3'd2) t = TAG_BIT_STRING;
    end else begin
      case (step)
        3'd1:    t = TAG_INTEGER;
        3'd3:    t = TAG_OCTET_STRING;
        default: t = TAG_SEQUENCE;
      endcase
    end
    return t;
  endfunction

  function automatic kind_t elem_kind(input logic fmt, input logic [2:0] step);
    kind_t k;
    k = K_LAST;
    case (step)
      3'd0:    k = K_HDR;
      3'd1:    k = K_SKIP;
      3'd2:    k = fmt ? K_SKIP : K_BITS;
      3'd3:    k = fmt ? K_HDR : K_LAST;
      default: k = K_LAST;
    endcase
    return k;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/der_key_header_skipper.sv =====
// ----------------------------------------------------------------------------
// der_key_header_skipper
// Finds the inner key SEQUENCE in a DER public or PKCS#8 key byte stream.
// ----------------------------------------------------------------------------
// Takes one key byte per clock while the output is not stalled, and returns
// at most one transaction per buffer for the byte that completes the inner
// header or fails: an input register feeds the walk step, whose verdict
// lands in the result register. The walk state advances by one byte each
// clock unless the output stalls, so this single loop sets the rate. The key
// format is sampled on the byte that carries the start mark.
`default_nettype none

module der_key_header_skipper #(
  parameter int MAX_LEN_BYTES = 4,
  parameter int OFFSET_WIDTH  = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic        cfg_key_format,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_start_of_buffer,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [15:0]      out_key_offset,
  output logic [1:0]       out_status
);

  logic               key_format_r;
  logic               in_valid_r;
  logic [7:0]         data_r;
  logic               sob_r;
  logic               go;
  logic               in_load;
  logic               out_valid_r, out_valid_nxt;
  logic [15:0]        key_offset_r;
  logic [1:0]         status_r;
  dks_pkg::walk_res_t res;

  assign go       = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = in_valid_r && !go;
  assign in_load  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_format_r <= 1'b0;
    end else if (cfg_wr_en) begin
      key_format_r <= cfg_key_format;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_valid_r || go) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_load) begin
      data_r <= in_data_byte;
      sob_r  <= in_start_of_buffer;
    end
  end

  dks_walk #(
    .MAX_LEN_BYTES (MAX_LEN_BYTES),
    .OFFSET_WIDTH  (OFFSET_WIDTH)
  ) u_walk (
    .clk             (clk),
    .rst_n           (rst_n),
    .go              (go),
    .data_byte       (data_r),
    .start_of_buffer (sob_r),
    .key_format      (key_format_r),
    .res             (res)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (go && res.hit) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (go && res.hit) begin
      key_offset_r <= res.key_offset;
      status_r     <= res.status;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_key_offset = key_offset_r;
  assign out_status     = status_r;

endmodule

`default_nettype wire

// ===== rtl/dks_walk.sv =====
// ----------------------------------------------------------------------------
// dks_walk
// Walk state and the per-byte step of the outer DER wrapper parser.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module dks_walk #(
  parameter int MAX_LEN_BYTES = 4,
  parameter int OFFSET_WIDTH  = 16
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              go,
  input  wire logic [7:0]        data_byte,
  input  wire logic              start_of_buffer,
  input  wire logic              key_format,
  output dks_pkg::walk_res_t     res
);

  localparam int LW = $clog2(MAX_LEN_BYTES + 1);

  dks_pkg::phase_t         phase_r, phase_nxt, phase_c;
  logic [OFFSET_WIDTH-1:0] offset_r, offset_nxt, offset_c;
  logic [31:0]             skip_r, skip_nxt, skip_c;
  logic [LW-1:0]           left_r, left_nxt, left_c;
  logic [2:0]              step_r, step_nxt, step_c;
  logic                    fmt_r, fmt_nxt, fmt_c;

  logic [7:0]              tag_exp;
  dks_pkg::kind_t          kind;
  logic [6:0]              len_n;
  logic [LW-1:0]           left_dec;
  logic [31:0]             skip_acc;
  logic [31:0]             skip_dec;
  logic [32:0]             off_ext;
  logic                    hdr_end;
  logic [31:0]             hdr_len;
  logic                    found;
  logic                    err;
  logic [1:0]              err_code;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= dks_pkg::PH_IDLE;
      offset_r <= '0;
      skip_r   <= '0;
      left_r   <= '0;
      step_r   <= '0;
      fmt_r    <= 1'b0;
    end else if (go) begin
      phase_r  <= phase_nxt;
      offset_r <= offset_nxt;
      skip_r   <= skip_nxt;
      left_r   <= left_nxt;
      step_r   <= step_nxt;
      fmt_r    <= fmt_nxt;
    end
  end

  // restart on a start mark, then step on this byte
  always_comb begin
    if (start_of_buffer) begin
      phase_c  = dks_pkg::PH_TAG;
      offset_c = '0;
      skip_c   = '0;
      left_c   = '0;
      step_c   = '0;
      fmt_c    = key_format;
    end else begin
      phase_c  = phase_r;
      offset_c = offset_r;
      skip_c   = skip_r;
      left_c   = left_r;
      step_c   = step_r;
      fmt_c    = fmt_r;
    end
  end

  assign tag_exp  = dks_pkg::elem_tag(fmt_c, step_c);
  assign kind     = dks_pkg::elem_kind(fmt_c, step_c);
  assign len_n    = 7'(data_byte & dks_pkg::LEN_N_MASK);
  assign left_dec = (left_c != '0) ? left_c - LW'(1) : left_c;
  assign skip_dec = (skip_c != '0) ? skip_c - 32'd1 : skip_c;
  assign skip_acc = (skip_c[31:24] != 8'd0) ? 32'hFFFF_FFFF : {skip_c[23:0], data_byte};
  assign off_ext  = 33'(offset_c);

  always_comb begin
    phase_nxt = phase_c;
    offset_nxt = offset_c;
    skip_nxt  = skip_c;
    left_nxt  = left_c;
    step_nxt  = step_c;
    fmt_nxt   = fmt_c;
    hdr_end   = 1'b0;
    hdr_len   = '0;
    found     = 1'b0;
    err       = 1'b0;
    err_code  = dks_pkg::ST_FOUND;

    unique case (phase_c)
      dks_pkg::PH_IDLE: begin
      end
      dks_pkg::PH_TAG: begin
        if (data_byte != tag_exp) begin
          err      = 1'b1;
          err_code = dks_pkg::ST_TAG_ERR;
        end else begin
          phase_nxt = dks_pkg::PH_LEN;
        end
      end
      dks_pkg::PH_LEN: begin
        if ((data_byte & dks_pkg::LEN_LONG_BIT) != 8'd0) begin
          if (int'(len_n) > MAX_LEN_BYTES) begin
            err      = 1'b1;
            err_code = dks_pkg::ST_LEN_ERR;
          end else if (len_n == 7'd0) begin
            hdr_end = 1'b1;
          end else begin
            left_nxt  = LW'(len_n);
            skip_nxt  = '0;
            phase_nxt = (kind == dks_pkg::K_SKIP) ? dks_pkg::PH_LEN_SKIP
                                                  : dks_pkg::PH_LEN_HDR;
          end
        end else begin
          hdr_end = 1'b1;
          hdr_len = 32'(data_byte);
        end
      end
      dks_pkg::PH_LEN_HDR: begin
        left_nxt = left_dec;
        if (left_dec == '0) hdr_end = 1'b1;
      end
      dks_pkg::PH_LEN_SKIP: begin
        skip_nxt = skip_acc;
        left_nxt = left_dec;
        if (left_dec == '0) begin
          hdr_end = 1'b1;
          hdr_len = skip_acc;
        end
      end
      dks_pkg::PH_SKIP: begin
        skip_nxt = skip_dec;
        if (skip_dec == '0) begin
          phase_nxt = dks_pkg::PH_TAG;
          if (step_c < dks_pkg::LAST_STEP) step_nxt = step_c + 3'd1;
        end
      end
      default: phase_nxt = dks_pkg::PH_IDLE;
    endcase

    if (hdr_end) begin
      case (kind)
        dks_pkg::K_LAST: found = 1'b1;
        dks_pkg::K_BITS: begin
          skip_nxt  = 32'd1;
          phase_nxt = dks_pkg::PH_SKIP;
        end
        dks_pkg::K_SKIP: begin
          if (hdr_len == '0) begin
            phase_nxt = dks_pkg::PH_TAG;
            if (step_c < dks_pkg::LAST_STEP) step_nxt = step_c + 3'd1;
          end else begin
            skip_nxt  = hdr_len;
            phase_nxt = dks_pkg::PH_SKIP;
          end
        end
        default: begin
          phase_nxt = dks_pkg::PH_TAG;
          if (step_c < dks_pkg::LAST_STEP) step_nxt = step_c + 3'd1;
        end
      endcase
    end

    if (phase_c != dks_pkg::PH_IDLE && !err && (&offset_c)) begin
      err      = 1'b1;
      err_code = dks_pkg::ST_OFF_OVFL;
    end

    if (err || found) begin
      phase_nxt = dks_pkg::PH_IDLE;
    end else if (phase_c != dks_pkg::PH_IDLE) begin
      offset_nxt = offset_c + OFFSET_WIDTH'(1);
    end
  end

  always_comb begin
    res.hit        = err || found;
    res.status     = err ? err_code : dks_pkg::ST_FOUND;
    res.key_offset = err ? off_ext[15:0] : off_ext[15:0] + 16'd1;
  end

  `DKS_ASSERT(a_idle_after_result, go && res.hit |=> phase_r == dks_pkg::PH_IDLE, "walk not idle after result")
  `DKS_ASSERT(a_skip_nonzero, phase_r == dks_pkg::PH_SKIP |-> skip_r != '0, "skip phase with zero count")
  `DKS_ASSERT(a_len_left, (phase_r == dks_pkg::PH_LEN_HDR || phase_r == dks_pkg::PH_LEN_SKIP) |-> left_r != '0, "length phase with no bytes left")
  `DKS_ASSERT(a_step_range, step_r <= dks_pkg::LAST_STEP, "element step out of range")

endmodule

`default_nettype wire

// ===== tb/tb_der_key_header_skipper.sv =====
// ----------------------------------------------------------------------------
// tb_der_key_header_skipper
// Self-checking bench for the DER key header walker.
// ----------------------------------------------------------------------------
// Streams DER key buffers into the walker one byte per transaction and checks
// every reported offset and status against a cycle-free model of the walk.
// A short hand-written sequence covers ignored bytes, restarts, both length
// forms and the tag and length error codes, then a buffer with a huge skipped element runs
// the offset counter into overflow. Random phases follow in both key formats:
// mostly well-formed buffers with random lengths and content, some corrupted
// or cut short, under varied sender gaps and receiver stalls, including one
// long receiver hold-off that backs the walker up into its input.

module tb_der_key_header_skipper;

  localparam int          LEN_BYTES_MAX = 4;
  localparam int unsigned OFFSET_LAST   = 32'h0000_FFFF;
  localparam int          HOLD_CYCLES   = 400;
  localparam int          DRAIN_CYCLES  = 4;

  typedef struct packed {
    logic [15:0] key_offset;
    logic [1:0]  status;
  } key_res_t;

  typedef struct packed {
    logic        sob;
    logic [7:0]  data;
    logic        typed;
    logic [15:0] off;
    logic [1:0]  st;
  } stim_row_t;

  logic        clk                = 1'b0;
  logic        rst_n              = 1'b0;
  logic        cfg_wr_en          = 1'b0;
  logic        cfg_key_format     = 1'b0;
  logic        in_valid           = 1'b0;
  logic        in_stall;
  logic [7:0]  in_data_byte       = 8'h00;
  logic        in_start_of_buffer = 1'b0;
  logic        out_valid;
  logic        out_stall          = 1'b0;
  logic [15:0] out_key_offset;
  logic [1:0]  out_status;

  int          send_idle_pct  = 0;
  int          recv_stall_pct = 0;
  int          hold_asked     = 0;
  int          hold_taken     = 0;
  int          hold_left      = 0;
  int          mismatches     = 0;

  key_res_t    offset_q[$];
  logic [7:0]  key_bytes[$];
  logic [7:0]  carry_bytes[$];
  stim_row_t   dir_tab [0:20];

  // walk model state
  dks_pkg::phase_t w_ph  = dks_pkg::PH_IDLE;
  int unsigned w_off     = 0;
  logic [31:0] w_skip    = '0;
  int          w_lenleft = 0;
  bit          w_done    = 1'b1;
  int          w_elem    = 0;
  logic        w_fmt     = 1'b0;
  logic        fmt_reg   = 1'b0;
  bit          walk_hit  = 1'b0;
  key_res_t    walk_res;

  der_key_header_skipper #(
    .MAX_LEN_BYTES(LEN_BYTES_MAX),
    .OFFSET_WIDTH (16)
  ) u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_key_format    (cfg_key_format),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_data_byte      (in_data_byte),
    .in_start_of_buffer(in_start_of_buffer),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_key_offset    (out_key_offset),
    .out_status        (out_status)
  );

  always #5 clk = ~clk;

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
  end

  initial begin
    #6000000;
    $display("== FAIL ==");
    $finish;
  end

  task automatic report_mismatch(input string what, input int want, input int got);
    $display("mismatch %s: expected %0d, got %0d at %0t", what, want, got, $time);
    mismatches++;
  endtask

  function automatic logic [7:0] walk_tag(input logic fmt, input int el);
    case (el)
      1:       return fmt ? dks_pkg::TAG_INTEGER : dks_pkg::TAG_SEQUENCE;
      2:       return fmt ? dks_pkg::TAG_SEQUENCE : dks_pkg::TAG_BIT_STRING;
      3:       return fmt ? dks_pkg::TAG_OCTET_STRING : dks_pkg::TAG_SEQUENCE;
      default: return dks_pkg::TAG_SEQUENCE;
    endcase
  endfunction

  function automatic dks_pkg::kind_t walk_kind(input logic fmt, input int el);
    case (el)
      0:       return dks_pkg::K_HDR;
      1:       return dks_pkg::K_SKIP;
      2:       return fmt ? dks_pkg::K_SKIP : dks_pkg::K_BITS;
      3:       return fmt ? dks_pkg::K_HDR : dks_pkg::K_LAST;
      default: return dks_pkg::K_LAST;
    endcase
  endfunction

  function automatic void advance_elem();
    if (w_elem < 4) w_elem++;
    w_ph = dks_pkg::PH_TAG;
  endfunction

  function automatic bit close_header(input logic [31:0] len);
    dks_pkg::kind_t k;
    k = walk_kind(w_fmt, w_elem);
    if (k == dks_pkg::K_LAST) return 1'b1;
    if (k == dks_pkg::K_HDR) begin
      advance_elem();
    end else if (k == dks_pkg::K_BITS) begin
      w_skip = 32'd1;
      w_ph   = dks_pkg::PH_SKIP;
    end else if (len == 0) begin
      advance_elem();
    end else begin
      w_skip = len;
      w_ph   = dks_pkg::PH_SKIP;
    end
    return 1'b0;
  endfunction

  function automatic void walk_key_byte(input logic [7:0] b, input logic sob);
    logic [39:0] acc;
    int          n;
    bit          fail;
    bit          found;
    logic [1:0]  code;
    walk_hit = 1'b0;
    fail     = 1'b0;
    found    = 1'b0;
    code     = dks_pkg::ST_FOUND;
    if (sob) begin
      w_off     = 0;
      w_elem    = 0;
      w_ph      = dks_pkg::PH_TAG;
      w_done    = 1'b0;
      w_fmt     = fmt_reg;
      w_skip    = '0;
      w_lenleft = 0;
    end
    if (w_done || w_ph == dks_pkg::PH_IDLE) return;
    case (w_ph)
      dks_pkg::PH_TAG: begin
        if (b != walk_tag(w_fmt, w_elem)) begin
          fail = 1'b1;
          code = dks_pkg::ST_TAG_ERR;
        end else begin
          w_ph = dks_pkg::PH_LEN;
        end
      end
      dks_pkg::PH_LEN: begin
        n = int'(b & dks_pkg::LEN_N_MASK);
        if ((b & dks_pkg::LEN_LONG_BIT) == 8'h00) begin
          found = close_header({24'd0, b});
        end else if (n > LEN_BYTES_MAX) begin
          fail = 1'b1;
          code = dks_pkg::ST_LEN_ERR;
        end else if (n == 0) begin
          found = close_header(32'd0);
        end else begin
          w_lenleft = n;
          w_skip    = '0;
          w_ph      = (walk_kind(w_fmt, w_elem) == dks_pkg::K_SKIP) ? dks_pkg::PH_LEN_SKIP
                                                                     : dks_pkg::PH_LEN_HDR;
        end
      end
      dks_pkg::PH_LEN_HDR: begin
        if (w_lenleft > 0) w_lenleft--;
        if (w_lenleft == 0) found = close_header(32'd0);
      end
      dks_pkg::PH_LEN_SKIP: begin
        acc = {w_skip, b};
        if (acc[39:32] != 8'h00) w_skip = 32'hFFFF_FFFF;
        else w_skip = acc[31:0];
        if (w_lenleft > 0) w_lenleft--;
        if (w_lenleft == 0) found = close_header(w_skip);
      end
      dks_pkg::PH_SKIP: begin
        if (w_skip > 0) w_skip--;
        if (w_skip == 0) advance_elem();
      end
      default: begin
        w_ph   = dks_pkg::PH_IDLE;
        w_done = 1'b1;
        return;
      end
    endcase
    if (!fail && w_off >= OFFSET_LAST) begin
      fail = 1'b1;
      code = dks_pkg::ST_OFF_OVFL;
    end
    if (fail) begin
      walk_hit            = 1'b1;
      walk_res.key_offset = w_off[15:0];
      walk_res.status     = code;
    end else if (found) begin
      walk_hit            = 1'b1;
      walk_res.key_offset = 16'(w_off + 1);
      walk_res.status     = dks_pkg::ST_FOUND;
    end else begin
      w_off++;
    end
    if (walk_hit) begin
      w_ph   = dks_pkg::PH_IDLE;
      w_done = 1'b1;
      offset_q.push_back(walk_res);
    end
  endfunction

  task automatic check_typed(input logic [15:0] off, input logic [1:0] st);
    if (!walk_hit) begin
      report_mismatch("missing verdict", 1, 0);
    end else begin
      if (walk_res.key_offset != off) report_mismatch("typed key_offset", off, walk_res.key_offset);
      if (walk_res.status != st) report_mismatch("typed status", st, walk_res.status);
    end
  endtask

  task automatic send_byte(input logic [7:0] b, input logic sob);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid           <= 1'b1;
    in_data_byte       <= b;
    in_start_of_buffer <= sob;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    walk_key_byte(b, sob);
  endtask

  task automatic push_len(input int unsigned v, input bit free_len);
    int c;
    if (free_len) begin
      c = $urandom_range(5);
      if (c == 5) begin
        key_bytes.push_back(8'($urandom_range(127)));
      end else begin
        key_bytes.push_back(dks_pkg::LEN_LONG_BIT | 8'(c));
        repeat (c) key_bytes.push_back(8'($urandom));
      end
    end else if (v == 0 && $urandom_range(2) == 0) begin
      key_bytes.push_back(dks_pkg::LEN_LONG_BIT);
    end else begin
      c = $urandom_range(4);
      if (c == 0) begin
        key_bytes.push_back(8'(v));
      end else begin
        key_bytes.push_back(dks_pkg::LEN_LONG_BIT | 8'(c));
        for (int i = c - 1; i >= 0; i--) key_bytes.push_back((i == 0) ? 8'(v) : 8'h00);
      end
    end
  endtask

  task automatic push_skipped(input logic [7:0] tag);
    int unsigned v;
    v = ($urandom_range(19) == 0) ? 127 : $urandom_range(10);
    key_bytes.push_back(tag);
    push_len(v, 1'b0);
    repeat (v) key_bytes.push_back(8'($urandom));
  endtask

  task automatic build_buffer(input logic fmt);
    key_bytes.delete();
    key_bytes.push_back(dks_pkg::TAG_SEQUENCE);
    push_len(0, 1'b1);
    if (fmt) begin
      push_skipped(dks_pkg::TAG_INTEGER);
      push_skipped(dks_pkg::TAG_SEQUENCE);
      key_bytes.push_back(dks_pkg::TAG_OCTET_STRING);
      push_len(0, 1'b1);
    end else begin
      push_skipped(dks_pkg::TAG_SEQUENCE);
      key_bytes.push_back(dks_pkg::TAG_BIT_STRING);
      push_len(0, 1'b1);
      key_bytes.push_back(8'($urandom));
    end
    key_bytes.push_back(dks_pkg::TAG_SEQUENCE);
    push_len(0, 1'b1);
  endtask

  task automatic wait_drained();
    while (offset_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic run_phase(input logic fmt, input int idle_pct, input int stall_pct,
                           input int n_bytes, input bit squeeze, input bit leave_part);
    int sent;
    int r;
    int pos;
    int cut;
    wait_drained();
    cfg_wr_en      <= 1'b1;
    cfg_key_format <= fmt;
    @(posedge clk);
    cfg_wr_en      <= 1'b0;
    fmt_reg         = fmt;
    send_idle_pct   = idle_pct;
    recv_stall_pct  = stall_pct;
    if (squeeze) hold_asked++;
    // finish the buffer left open across the format change
    while (carry_bytes.size() != 0) send_byte(carry_bytes.pop_front(), 1'b0);
    sent = 0;
    while (sent < n_bytes) begin
      build_buffer(fmt);
      r   = $urandom_range(99);
      pos = $urandom_range(key_bytes.size() - 1);
      if (r < 10) begin
        key_bytes[pos] = 8'($urandom);
      end else if (r < 16) begin
        key_bytes[1] = 8'($urandom_range(255, 133));
      end else if (r < 22) begin
        while (key_bytes.size() > pos + 1) void'(key_bytes.pop_back());
      end
      sent += key_bytes.size();
      for (int i = 0; i < key_bytes.size(); i++) send_byte(key_bytes[i], i == 0);
      if ($urandom_range(9) == 0) repeat ($urandom_range(3, 1)) send_byte(8'($urandom), 1'b0);
    end
    if (leave_part) begin
      build_buffer(fmt);
      cut = key_bytes.size() / 2;
      for (int i = 0; i < key_bytes.size(); i++) begin
        if (i < cut) send_byte(key_bytes[i], i == 0);
        else carry_bytes.push_back(key_bytes[i]);
      end
    end
    in_valid <= 1'b0;
  endtask

  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_taken != hold_asked) begin
      out_stall  <= 1'b1;
      hold_left  <= HOLD_CYCLES;
      hold_taken <= hold_taken + 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin : result_check
    key_res_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (offset_q.size() == 0) begin
        report_mismatch("unexpected transaction", -1, {out_key_offset, out_status});
      end else begin
        want = offset_q.pop_front();
        if (out_key_offset !== want.key_offset)
          report_mismatch("key_offset", want.key_offset, out_key_offset);
        if (out_status !== want.status)
          report_mismatch("status", want.status, out_status);
      end
    end
  end

  initial begin
    dir_tab = '{
      '{1'b0, 8'h30, 1'b0, 16'd0,  dks_pkg::ST_FOUND},
      '{1'b1, 8'h30, 1'b0, 16'd0,  dks_pkg::ST_FOUND},
      '{1'b0, 8'h84, 1'b0, 16'd0,  dks_pkg::ST_FOUND},
      '{1'b1, 8'h30, 1'b0, 16'd0,  dks_pkg::ST_FOUND},
      '{1'b0, 8'h81, 1'b0, 16'd0,  dks_pkg::ST_FOUND},
      '{1'b0, 8'hFF, 1'b0, 16'd0,  dks_pkg::ST_FOUND},
      '{1'b0, 8'h30, 1'b0, 16'd0,  dks_pkg::ST_FOUND},
      '{1'b0, 8'h80, 1'b0, 16'd0,  dks_pkg::ST_FOUND},
      '{1'b0, 8'h03, 1'b0, 16'd0,  dks_pkg::ST_FOUND},
      '{1'b0, 8'h05, 1'b0, 16'd0,  dks_pkg::ST_FOUND},
      '{1'b0, 8'h00, 1'b0, 16'd0,  dks_pkg::ST_FOUND},
      '{1'b0, 8'h30, 1'b0, 16'd0,  dks_pkg::ST_FOUND},
      '{1'b0, 8'h82, 1'b0, 16'd0,  dks_pkg::ST_FOUND},
      '{1'b0, 8'h01, 1'b0, 16'd0,  dks_pkg::ST_FOUND},
      '{1'b0, 8'h00, 1'b1, 16'd12, dks_pkg::ST_FOUND},
      '{1'b1, 8'h31, 1'b1, 16'd0,  dks_pkg::ST_TAG_ERR},
      '{1'b1, 8'h30, 1'b0, 16'd0,  dks_pkg::ST_FOUND},
      '{1'b0, 8'h85, 1'b1, 16'd1,  dks_pkg::ST_LEN_ERR},
      '{1'b1, 8'h30, 1'b0, 16'd0,  dks_pkg::ST_FOUND},
      '{1'b0, 8'h7F, 1'b0, 16'd0,  dks_pkg::ST_FOUND},
      '{1'b1, 8'h02, 1'b1, 16'd0,  dks_pkg::ST_TAG_ERR}
    };
    while (!rst_n) @(posedge clk);

    foreach (dir_tab[i]) begin
      send_byte(dir_tab[i].data, dir_tab[i].sob);
      if (dir_tab[i].typed) check_typed(dir_tab[i].off, dir_tab[i].st);
    end

    // huge skipped element: run the offset counter off its end
    send_byte(dks_pkg::TAG_SEQUENCE, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(dks_pkg::TAG_SEQUENCE, 1'b0);
    send_byte(dks_pkg::LEN_LONG_BIT | 8'd4, 1'b0);
    repeat (4) send_byte(8'hFF, 1'b0);
    while (!walk_hit) send_byte(8'($urandom), 1'b0);
    check_typed(16'hFFFF, dks_pkg::ST_OFF_OVFL);
    in_valid <= 1'b0;

    run_phase(1'b0, 0,  0,  170, 1'b0, 1'b1);
    run_phase(1'b1, 0,  0,  170, 1'b0, 1'b1);
    run_phase(1'b1, 67, 0,  170, 1'b0, 1'b1);
    run_phase(1'b0, 0,  67, 170, 1'b0, 1'b1);
    run_phase(1'b1, 29, 29, 170, 1'b0, 1'b1);
    run_phase(1'b1, 0,  0,  120, 1'b1, 1'b1);
    run_phase(1'b0, 29, 29, 120, 1'b0, 1'b0);

    while (offset_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
